/* rtl/tss_pkg.sv */
package tss_pkg;

  // Input function codes.
  localparam logic FUNC_TEXEL = 1'b0;
  localparam logic FUNC_DRAW  = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOG_COLOUR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOG_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 3'd6;

  localparam logic [8:0] GAIN_UNITY = 9'd256;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tex_write;
    logic load_start;
    logic issue;
    logic issue_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;
    logic adv;
  } stat_t;

endpackage

/* rtl/tss_ctrl.sv */
module tss_ctrl #(
  parameter int MAX_RUN = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_func,
  input  logic             in_continue_run,
  input  logic [6:0]       in_pixel_count,
  input  tss_pkg::stat_t   stat,
  output tss_pkg::cmd_t    cmd
);

  localparam int CNT_W = $clog2(MAX_RUN + 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] remaining_r, remaining_nxt;
  logic [CNT_W-1:0] sat_count;
  logic             accept;

  assign in_stall = (state_r != ST_IDLE) || stat.busy;
  assign accept = in_valid && !in_stall;
  assign sat_count = (in_pixel_count > 7'(MAX_RUN)) ? CNT_W'(MAX_RUN)
                                                    : CNT_W'(in_pixel_count);

  always_comb begin
    state_nxt = state_r;
    remaining_nxt = remaining_r;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == tss_pkg::FUNC_TEXEL) begin
            cmd.tex_write = 1'b1;
          end else begin
            cmd.load_start = !in_continue_run;
            if (sat_count != '0) begin
              state_nxt = ST_RUN;
              remaining_nxt = sat_count;
            end
          end
        end
      end
      ST_RUN: begin
        // One pixel enters the pipeline in every cycle the pipeline moves.
        if (stat.adv) begin
          cmd.issue = 1'b1;
          cmd.issue_last = (remaining_r == CNT_W'(1));
          remaining_nxt = remaining_r - CNT_W'(1);
          if (remaining_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      remaining_r <= '0;
    end else begin
      state_r <= state_nxt;
      remaining_r <= remaining_nxt;
    end
  end

  run_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> remaining_r != '0)
    else $error("run state entered with no pixels left");

  issue_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> state_r == ST_RUN && stat.adv)
    else $error("pixel issued outside a run or into a frozen pipeline");

  last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue_last |=> state_r == ST_IDLE)
    else $error("run did not end after its last pixel");

endmodule

/* rtl/tss_datapath.sv */
module tss_datapath #(
  parameter int TEX_SIZE = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tss_pkg::cmd_t                     cmd,
  output tss_pkg::stat_t                    stat,
  input  logic [11:0]                       in_texel_address,
  input  logic [15:0]                       in_texel_value,
  input  logic [31:0]                       in_start_x,
  input  logic [31:0]                       in_start_y,
  input  logic                              cfg_we,
  input  logic [tss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tss_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [15:0]                       out_pixel_colour,
  output logic                              out_last_pixel
);

  localparam int DEPTH = TEX_SIZE * TEX_SIZE;
  localparam int AW = $clog2(DEPTH);
  localparam int RW = $clog2(TEX_SIZE);
  // Reciprocals for the modulo by a constant; the floor estimate is at most
  // one short, so a single compare and subtract fixes the remainder.
  localparam logic [31:0] RECIP_T = 32'(64'h1_0000_0000 / TEX_SIZE);
  localparam logic [31:0] RECIP_D = 32'(64'h1_0000_0000 / DEPTH);

  // Configuration registers.
  logic [8:0]  gain_red_r, gain_green_r, gain_blue_r;
  logic [15:0] fog_colour_r;
  logic        fog_mode_r;
  logic [31:0] step_x_r, step_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_red_r <= tss_pkg::GAIN_UNITY;
      gain_green_r <= tss_pkg::GAIN_UNITY;
      gain_blue_r <= tss_pkg::GAIN_UNITY;
      fog_colour_r <= '0;
      fog_mode_r <= 1'b0;
      step_x_r <= '0;
      step_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tss_pkg::REG_GAIN_RED:   gain_red_r <= cfg_data[8:0];
        tss_pkg::REG_GAIN_GREEN: gain_green_r <= cfg_data[8:0];
        tss_pkg::REG_GAIN_BLUE:  gain_blue_r <= cfg_data[8:0];
        tss_pkg::REG_FOG_COLOUR: fog_colour_r <= cfg_data[15:0];
        tss_pkg::REG_FOG_MODE:   fog_mode_r <= cfg_data[0];
        tss_pkg::REG_STEP_X:     step_x_r <= cfg_data;
        tss_pkg::REG_STEP_Y:     step_y_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Texture coordinates.
  logic [31:0] coord_x_r, coord_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_x_r <= '0;
      coord_y_r <= '0;
    end else if (cmd.load_start) begin
      coord_x_r <= in_start_x;
      coord_y_r <= in_start_y;
    end else if (cmd.issue) begin
      coord_x_r <= coord_x_r + step_x_r;
      coord_y_r <= coord_y_r + step_y_r;
    end
  end

  // The whole pixel pipeline moves together; it freezes while a result
  // waits at the output.
  logic adv;
  logic out_valid_r, out_last_r;
  logic [15:0] out_colour_r;
  assign adv = !out_valid_r || !out_stall;

  logic va_r, vb_r, vc_r, vd_r, ve_r;
  logic la_r, lb_r, lc_r, ld_r, le_r;

  // Stage A: quotient estimates of the integer coordinates.
  logic [47:0] qx_full, qy_full;
  logic [15:0] vx_a_r, vy_a_r, qx_a_r, qy_a_r;
  assign qx_full = 48'(coord_x_r[31:16]) * 48'(RECIP_T);
  assign qy_full = 48'(coord_y_r[31:16]) * 48'(RECIP_T);

  // Stage B: row and column.
  logic [15:0] rx_raw, ry_raw, rx_fix, ry_fix;
  logic [RW-1:0] row_b_r, col_b_r;
  assign rx_raw = vx_a_r - 16'(32'(qx_a_r) * 32'(TEX_SIZE));
  assign ry_raw = vy_a_r - 16'(32'(qy_a_r) * 32'(TEX_SIZE));
  assign rx_fix = (rx_raw >= 16'(TEX_SIZE)) ? rx_raw - 16'(TEX_SIZE) : rx_raw;
  assign ry_fix = (ry_raw >= 16'(TEX_SIZE)) ? ry_raw - 16'(TEX_SIZE) : ry_raw;

  // Stage C: texture address. Stage D: texel read.
  logic [AW-1:0] addr_c_r;
  logic [15:0] texel_d_r;

  // Stage E: per-field products.
  logic [13:0] prod_r_r, prod_g_r, prod_b_r;
  logic [15:0] lit_colour, out_colour_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      va_r <= cmd.issue;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      out_valid_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      la_r <= cmd.issue_last;
      vx_a_r <= coord_x_r[31:16];
      vy_a_r <= coord_y_r[31:16];
      qx_a_r <= qx_full[47:32];
      qy_a_r <= qy_full[47:32];

      lb_r <= la_r;
      row_b_r <= RW'(rx_fix);
      col_b_r <= RW'(ry_fix);

      lc_r <= lb_r;
      addr_c_r <= AW'(32'(row_b_r) * 32'(TEX_SIZE) + 32'(col_b_r));

      ld_r <= lc_r;

      le_r <= ld_r;
      prod_b_r <= 14'(texel_d_r[4:0]) * 14'(gain_blue_r);
      prod_g_r <= 14'(texel_d_r[10:6]) * 14'(gain_green_r);
      prod_r_r <= 14'(texel_d_r[15:11]) * 14'(gain_red_r);

      out_last_r <= le_r;
      out_colour_r <= out_colour_nxt;
    end
  end

  // Blue sits in bits 13..0 of the lit word, green in 18..14 and red in
  // 23..19; the result is bits 23..8 of that word.
  assign lit_colour = {prod_r_r[12:8], prod_g_r[12:8], prod_b_r[13:8]};
  assign out_colour_nxt = fog_mode_r ? lit_colour + fog_colour_r : lit_colour;

  // Texel write path: the address is reduced modulo the store depth in the
  // cycle after the beat is taken.
  logic        w_valid_r;
  logic [11:0] w_addr_r, w_q_r;
  logic [15:0] w_data_r;
  logic [43:0] wq_full;
  logic [31:0] wrem_raw, wrem_fix;
  assign wq_full = 44'(in_texel_address) * 44'(RECIP_D);
  assign wrem_raw = 32'(w_addr_r) - 32'(w_q_r) * 32'(DEPTH);
  assign wrem_fix = (wrem_raw >= 32'(DEPTH)) ? wrem_raw - 32'(DEPTH) : wrem_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r <= 1'b0;
    end else begin
      w_valid_r <= cmd.tex_write;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tex_write) begin
      w_addr_r <= in_texel_address;
      w_data_r <= in_texel_value;
      w_q_r <= wq_full[43:32];
    end
  end

  logic [15:0] tex_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (w_valid_r) begin
      tex_mem[AW'(wrem_fix)] <= w_data_r;
    end
    if (adv) begin
      texel_d_r <= tex_mem[addr_c_r];
    end
  end

  assign stat.adv = adv;
  assign stat.busy = va_r || vb_r || vc_r || vd_r || ve_r || w_valid_r;

  assign out_valid = out_valid_r;
  assign out_pixel_colour = out_colour_r;
  assign out_last_pixel = out_last_r;

  frozen_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({va_r, vb_r, vc_r, vd_r, ve_r, out_valid_r}))
    else $error("pixel pipeline moved while the output was stalled");

  no_write_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    w_valid_r |-> !(va_r || vb_r || vc_r || vd_r))
    else $error("texel write overlaps pixels still reading the texture");

  issue_needs_advance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> adv && !cmd.tex_write && !cmd.load_start)
    else $error("pixel issued into a frozen pipeline or with another command");

endmodule

/* rtl/textured_span_shader_top.sv */
// Affine span mapper over a TEX_SIZE x TEX_SIZE texture of 565 texels. An
// input beat either writes one texel (func 0) or draws a run of up to MAX_RUN
// pixels (func 1), starting from the given 16.16 coordinates or from those left
// by the previous run. A texel write holds off the next beat until it is stored.
// A draw issues one pixel per cycle while the pipeline advances, limited by the
// single read port of the texture memory, through stages A to E and the output
// register; the input is held off until the run is issued and has left stage E.
// An output stall freezes the whole pipeline. The next beat may be taken while
// the final pixel still waits in the output register. The texture is not cleared
// at reset and must be written before it is drawn from.
module textured_span_shader_top #(
  parameter int TEX_SIZE = 64,
  parameter int MAX_RUN = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic [11:0]                    in_texel_address,
  input  logic [15:0]                    in_texel_value,
  input  logic                           in_continue_run,
  input  logic [31:0]                    in_start_x,
  input  logic [31:0]                    in_start_y,
  input  logic [6:0]                     in_pixel_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    out_pixel_colour,
  output logic                           out_last_pixel,
  input  logic                           cfg_we,
  input  logic [tss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tss_pkg::CFG_DATA_W-1:0] cfg_data
);

  tss_pkg::cmd_t  cmd;
  tss_pkg::stat_t stat;

  tss_ctrl #(
    .MAX_RUN(MAX_RUN)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_continue_run(in_continue_run),
    .in_pixel_count(in_pixel_count),
    .stat(stat),
    .cmd(cmd)
  );

  tss_datapath #(
    .TEX_SIZE(TEX_SIZE)
  ) u_datapath (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .stat(stat),
    .in_texel_address(in_texel_address),
    .in_texel_value(in_texel_value),
    .in_start_x(in_start_x),
    .in_start_y(in_start_y),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pixel_colour(out_pixel_colour),
    .out_last_pixel(out_last_pixel)
  );

endmodule
